// ===== sv/ctsp_pkg.sv =====
package ctsp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_Z = 8'h5A;

    // Layout and range limits
    localparam int unsigned POS_MAX       = 31;
    localparam int unsigned YLEN_SHORT    = 2;
    localparam int unsigned YLEN_LONG     = 4;
    localparam int unsigned BODY_LEN      = 10;
    localparam int unsigned PIVOT_YEAR    = 50;
    localparam int unsigned BASE_20XX     = 2000;
    localparam int unsigned BASE_19XX     = 1900;
    localparam int unsigned YEAR_MAX      = 9999;
    localparam int unsigned HOUR_MAX      = 23;
    localparam int unsigned MINSEC_MAX    = 59;
    localparam int unsigned CENTURY       = 100;

    // Reciprocal of 100: q = (y * RECIP_100) >> RECIP_SHIFT, exact for y up to 16383
    localparam int unsigned RECIP_100     = 5243;
    localparam int unsigned RECIP_SHIFT   = 19;

    // Field index within the body (after the year)
    localparam logic [2:0] FLD_MONTH  = 3'd0;
    localparam logic [2:0] FLD_DAY    = 3'd1;
    localparam logic [2:0] FLD_HOUR   = 3'd2;
    localparam logic [2:0] FLD_MINUTE = 3'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       short_year;
        logic       last;
    } chr_word_t;

    typedef struct packed {
        logic        status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } res_word_t;

    // Accumulated fields of one finished time value
    typedef struct packed {
        logic [13:0] year_acc;
        logic [6:0]  month_acc;
        logic [6:0]  day_acc;
        logic [6:0]  hour_acc;
        logic [6:0]  minute_acc;
        logic [6:0]  second_acc;
        logic        format_bad;
        logic        len_ok;
        logic        short_year;
    } fin_t;

    // Fields after year mapping and range checks
    typedef struct packed {
        logic [13:0] year;
        logic [7:0]  cent_q;
        logic [6:0]  month_acc;
        logic [6:0]  day_acc;
        logic [6:0]  hour_acc;
        logic [6:0]  minute_acc;
        logic [6:0]  second_acc;
        logic        bad;
    } chk_t;

endpackage

// ===== sv/cert_time_string_parser.sv =====
// A result word passes from the edge that accepts the character marked last through the
// final-field register, the year/range register and, after the calendar check, the result register.
// Throughput: one character per cycle; ready drops only when the result stage stalls.
// Reset: rst_n is asynchronous and active low; it clears the character position, the
// accumulators, the format flag and all stage valid bits.
module cert_time_string_parser
    import ctsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      chr_valid,
    output logic      chr_ready,
    input  chr_word_t chr_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_word_t res_data
);

    // Parse state
    logic [4:0]  pos_reg, pos_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic        bad_reg, bad_next;

    // Pipeline stages
    logic      fin_valid_reg;
    fin_t      fin_reg, fin_next;
    logic      chk_valid_reg;
    chk_t      chk_reg, chk_next;
    logic      out_valid_reg;
    res_word_t out_reg, out_next;

    logic fin_ready, chk_ready, out_ready;
    logic chr_acc;

    logic       digit;
    logic [3:0] dval;
    logic [4:0] ylen;
    logic [4:0] rel;
    logic [2:0] fld;

    // Stage-two helpers
    logic [14:0] year_full;
    logic [26:0] recip_prod;

    // Stage-three helpers
    logic [14:0] cent_back;
    logic        century, leap;
    logic [4:0]  dim;
    logic        ok;

    // Ready chain from the result side back to the character side
    assign out_ready = !out_valid_reg || res_ready;
    assign chk_ready = !chk_valid_reg || out_ready;
    assign fin_ready = !fin_valid_reg || chk_ready;
    assign chr_ready = fin_ready;
    assign chr_acc   = chr_valid && chr_ready;

    // Decode the character against its position
    always_comb
    begin
        digit = chr_data.char_code inside {[CHAR_0:CHAR_9]};
        dval  = digit ? 4'(chr_data.char_code - CHAR_0) : 4'd0;
        ylen  = chr_data.short_year ? 5'(YLEN_SHORT) : 5'(YLEN_LONG);
        rel   = pos_reg - ylen;
        fld   = rel[3:1];

        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        bad_next    = bad_reg;

        if (pos_reg < ylen + 5'(BODY_LEN))
        begin
            if (!digit)
            begin
                bad_next = 1'b1;
            end
            else if (pos_reg < ylen)
            begin
                year_next = (year_reg << 3) + (year_reg << 1) + 14'(dval);
            end
            else
            begin
                case (fld)
                    FLD_MONTH:  month_next  = (month_reg << 3) + (month_reg << 1) + 7'(dval);
                    FLD_DAY:    day_next    = (day_reg << 3) + (day_reg << 1) + 7'(dval);
                    FLD_HOUR:   hour_next   = (hour_reg << 3) + (hour_reg << 1) + 7'(dval);
                    FLD_MINUTE: minute_next = (minute_reg << 3) + (minute_reg << 1)
                                              + 7'(dval);
                    default:    second_next = (second_reg << 3) + (second_reg << 1)
                                              + 7'(dval);
                endcase
            end
        end
        else if (pos_reg == ylen + 5'(BODY_LEN))
        begin
            if (chr_data.char_code != CHAR_Z || !chr_data.last)
            begin
                bad_next = 1'b1;
            end
        end
        else
        begin
            bad_next = 1'b1;
        end

        pos_next = (pos_reg < 5'(POS_MAX)) ? pos_reg + 5'd1 : pos_reg;

        fin_next.year_acc   = year_next;
        fin_next.month_acc  = month_next;
        fin_next.day_acc    = day_next;
        fin_next.hour_acc   = hour_next;
        fin_next.minute_acc = minute_next;
        fin_next.second_acc = second_next;
        fin_next.format_bad = bad_next;
        fin_next.len_ok     = pos_reg >= ylen + 5'(BODY_LEN - 1);
        fin_next.short_year = chr_data.short_year;
    end

    // Advance parse state; drop back to the start after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            bad_reg    <= 1'b0;
        end
        else if (chr_acc)
        begin
            if (chr_data.last)
            begin
                pos_reg    <= '0;
                year_reg   <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
                bad_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                bad_reg    <= bad_next;
            end
        end
    end

    // Map the year and run the range checks
    always_comb
    begin
        if (fin_reg.short_year)
        begin
            year_full = {1'b0, fin_reg.year_acc}
                        + ((fin_reg.year_acc < 14'(PIVOT_YEAR)) ? 15'(BASE_20XX)
                                                                : 15'(BASE_19XX));
        end
        else
        begin
            year_full = {1'b0, fin_reg.year_acc};
        end

        recip_prod = 27'(year_full[13:0]) * 27'(RECIP_100);

        chk_next.year       = year_full[13:0];
        chk_next.cent_q     = recip_prod[26:RECIP_SHIFT];
        chk_next.month_acc  = fin_reg.month_acc;
        chk_next.day_acc    = fin_reg.day_acc;
        chk_next.hour_acc   = fin_reg.hour_acc;
        chk_next.minute_acc = fin_reg.minute_acc;
        chk_next.second_acc = fin_reg.second_acc;
        chk_next.bad        = fin_reg.format_bad || !fin_reg.len_ok
                              || year_full > 15'(YEAR_MAX)
                              || fin_reg.hour_acc > 7'(HOUR_MAX)
                              || fin_reg.minute_acc > 7'(MINSEC_MAX)
                              || fin_reg.second_acc > 7'(MINSEC_MAX);
    end

    // Check the day against the month length and build the result word
    always_comb
    begin
        cent_back = (15'(chk_reg.cent_q) << 6) + (15'(chk_reg.cent_q) << 5)
                    + (15'(chk_reg.cent_q) << 2);
        century   = {1'b0, chk_reg.year} == cent_back;
        leap      = (chk_reg.year[1:0] == 2'd0)
                    && (!century || chk_reg.cent_q[1:0] == 2'd0);

        case (chk_reg.month_acc) inside
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: dim = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    dim = 5'd30;
            7'd2:                                       dim = leap ? 5'd29 : 5'd28;
            default:                                    dim = 5'd0;
        endcase

        ok = !chk_reg.bad && dim != 5'd0 && chk_reg.day_acc != 7'd0
             && chk_reg.day_acc <= 7'(dim);

        if (ok)
        begin
            out_next.status = 1'b0;
            out_next.year   = chk_reg.year;
            out_next.month  = chk_reg.month_acc[3:0];
            out_next.day    = chk_reg.day_acc[4:0];
            out_next.hour   = chk_reg.hour_acc[4:0];
            out_next.minute = chk_reg.minute_acc[5:0];
            out_next.second = chk_reg.second_acc[5:0];
        end
        else
        begin
            out_next        = '0;
            out_next.status = 1'b1;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_ready)
            begin
                fin_valid_reg <= chr_acc && chr_data.last;
            end
            if (chk_ready)
            begin
                chk_valid_reg <= fin_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= chk_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (chr_acc && chr_data.last)
        begin
            fin_reg <= fin_next;
        end
        if (chk_ready && fin_valid_reg)
        begin
            chk_reg <= chk_next;
        end
        if (out_ready && chk_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // An invalid status carries an all-zero date
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status |->
            res_data.year == '0 && res_data.month == '0 && res_data.day == '0
            && res_data.hour == '0 && res_data.minute == '0 && res_data.second == '0)
        else $error("invalid result carries nonzero date fields");

    // A valid status carries an in-range calendar date
    a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.status |->
            res_data.month >= 4'd1 && res_data.month <= 4'd12
            && res_data.day >= 5'd1 && res_data.day <= 5'd31
            && res_data.hour <= 5'd23 && res_data.minute <= 6'd59
            && res_data.second <= 6'd59 && res_data.year <= 14'd9999)
        else $error("valid result has a field out of range");

    // The last character restarts parsing from position zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        chr_acc && chr_data.last |=> pos_reg == '0 && !bad_reg && fin_valid_reg)
        else $error("parse state not restarted after last character");

endmodule
